### rtl/euler_to_rotation_matrix_macros.svh
// Assertion macros for the Euler angle to rotation matrix block.
// Expects clk and rst_n in the scope of each use.
`ifndef EULER_TO_ROTATION_MATRIX_MACROS_SVH
`define EULER_TO_ROTATION_MATRIX_MACROS_SVH

// Check that a condition implies a consequence in the same cycle
`define E2R_ASSERT_NOW(lbl, cond, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
        else $error("e2r: same-cycle check failed");

// Check that a condition implies a consequence in the next cycle
`define E2R_ASSERT_NEXT(lbl, cond, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
        else $error("e2r: next-cycle check failed");

`endif

### rtl/e2r_pkg.sv
// Shared types, constants and the arctangent table of the Euler to matrix block.
// No dependencies.
package e2r_pkg;

    typedef logic signed [15:0] q14_t;
    typedef logic signed [27:0] q24_t;

    localparam logic [2:0] ORD_XYZ = 3'd0;
    localparam logic [2:0] ORD_YZX = 3'd1;
    localparam logic [2:0] ORD_ZXY = 3'd2;
    localparam logic [2:0] ORD_ZYX = 3'd3;
    localparam logic [2:0] ORD_YXZ = 3'd4;
    localparam logic [2:0] ORD_XZY = 3'd5;

    localparam logic signed [16:0] PI_Q12      = 17'sd12868;
    localparam logic signed [16:0] HALF_PI_Q12 = 17'sd6434;
    localparam logic signed [16:0] TWO_PI_Q12  = 17'sd25736;
    localparam q24_t               GAIN_Q24    = 28'sd10188014;
    localparam logic signed [27:0] ONE_Q14     = 28'sd16384;

    // atan(2^-i) in Q24
    function automatic q24_t atan_q24(input logic [4:0] i);
        q24_t r;
        unique case (i)
            5'd0:  r = 28'sd13176795;
            5'd1:  r = 28'sd7778716;
            5'd2:  r = 28'sd4110060;
            5'd3:  r = 28'sd2086331;
            5'd4:  r = 28'sd1047214;
            5'd5:  r = 28'sd524117;
            5'd6:  r = 28'sd262123;
            5'd7:  r = 28'sd131069;
            5'd8:  r = 28'sd65536;
            5'd9:  r = 28'sd32768;
            5'd10: r = 28'sd16384;
            5'd11: r = 28'sd8192;
            5'd12: r = 28'sd4096;
            5'd13: r = 28'sd2048;
            5'd14: r = 28'sd1024;
            5'd15: r = 28'sd512;
            5'd16: r = 28'sd256;
            5'd17: r = 28'sd128;
            5'd18: r = 28'sd64;
            5'd19: r = 28'sd32;
            5'd20: r = 28'sd16;
            5'd21: r = 28'sd8;
            5'd22: r = 28'sd4;
            5'd23: r = 28'sd2;
            5'd24: r = 28'sd1;
            default: r = 28'sd0;
        endcase
        return r;
    endfunction

endpackage

### rtl/e2r_if.sv
// Valid/ready channel interfaces for angle requests and matrix results.
// Depends on e2r_pkg.
interface e2r_angle_if import e2r_pkg::*;;
    logic valid;
    logic ready;
    logic signed [15:0] angle_x;
    logic signed [15:0] angle_y;
    logic signed [15:0] angle_z;
    modport source (output valid, angle_x, angle_y, angle_z, input ready);
    modport sink   (input valid, angle_x, angle_y, angle_z, output ready);
endinterface

interface e2r_matrix_if import e2r_pkg::*;;
    logic valid;
    logic ready;
    q14_t m00, m01, m02, m10, m11, m12, m20, m21, m22;
    modport source (output valid, m00, m01, m02, m10, m11, m12, m20, m21, m22,
                    input ready);
    modport sink   (input valid, m00, m01, m02, m10, m11, m12, m20, m21, m22,
                    output ready);
endinterface

### rtl/euler_to_rotation_matrix.sv
// Top level: Euler angles in, 3x3 rotation matrix out, fully pipelined.
// Depends on e2r_pkg, e2r_if, e2r_cordic and the assertion macro header.
//
// Usage:
//   angles (sink) takes one request of angle_x, angle_y, angle_z (Q3.12 rad)
//   at each edge where valid and ready are high. matrix (source) returns the
//   nine elements m00..m22 in Q2.14, saturated to plus or minus one.
//   cfg_we/cfg_data write the rotation order (0 XYZ, 1 YZX, 2 ZXY, 3 ZYX,
//   4 YXZ, 5 XZY, other codes give ZYX); write it only while the pipe is empty.
//   From accept to matrix.valid, each request passes through an angle
//   fold stage, one CORDIC iteration per stage, a rounding stage, pair
//   products, triple products, element sums and the output register.
//   Throughput is one request per cycle while matrix.ready is high, set by the stage-per-iteration CORDIC.
//   Each stage has its own valid bit; a stage loads when it is empty or its
//   successor moves, so bubbles close up while matrix.ready is low and
//   nothing is lost or repeated. Reset empties the pipe and sets order ZYX.
module euler_to_rotation_matrix import e2r_pkg::*;
#(
    parameter int CORDIC_STAGES = 16
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_we,
    input  logic [2:0]   cfg_data,
    e2r_angle_if.sink    angles,
    e2r_matrix_if.source matrix
);

`include "euler_to_rotation_matrix_macros.svh"

    localparam int CL = CORDIC_STAGES + 2;
    localparam int L  = CL + 4;

    logic [2:0]   order_reg;
    logic [L-1:0] vld_reg;
    logic [L-1:0] adv;

    // Hold the rotation order
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            order_reg <= ORD_ZYX;
        else if (cfg_we)
            order_reg <= cfg_data;
    end

    // Advance a stage when it is empty or its successor advances
    always_comb
    begin
        adv[L-1] = !vld_reg[L-1] || matrix.ready;
        for (int k = L - 2; k >= 0; k--)
            adv[k] = !vld_reg[k] || adv[k+1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
        begin
            if (adv[0])
                vld_reg[0] <= angles.valid;
            for (int k = 1; k < L; k++)
                if (adv[k])
                    vld_reg[k] <= vld_reg[k-1];
        end
    end

    assign angles.ready = adv[0];

    // Sine and cosine per axis; index 0 cosine, 1 sine
    q14_t sc [0:2][0:1];

    e2r_cordic #(.STAGES(CORDIC_STAGES)) u_cordic_x (
        .clk(clk), .en(adv[CL-1:0]), .angle(angles.angle_x),
        .sin_q14(sc[0][1]), .cos_q14(sc[0][0]));
    e2r_cordic #(.STAGES(CORDIC_STAGES)) u_cordic_y (
        .clk(clk), .en(adv[CL-1:0]), .angle(angles.angle_y),
        .sin_q14(sc[1][1]), .cos_q14(sc[1][0]));
    e2r_cordic #(.STAGES(CORDIC_STAGES)) u_cordic_z (
        .clk(clk), .en(adv[CL-1:0]), .angle(angles.angle_z),
        .sin_q14(sc[2][1]), .cos_q14(sc[2][0]));

    // Pair products in Q28
    logic signed [29:0] pxy_reg [0:1][0:1];
    logic signed [29:0] pxz_reg [0:1][0:1];
    logic signed [29:0] pyz_reg [0:1][0:1];
    q14_t               sc1_reg [0:2][0:1];

    always_ff @(posedge clk)
    begin
        if (adv[CL])
        begin
            for (int i = 0; i < 2; i++)
                for (int j = 0; j < 2; j++)
                begin
                    pxy_reg[i][j] <= 30'(sc[0][i]) * 30'(sc[1][j]);
                    pxz_reg[i][j] <= 30'(sc[0][i]) * 30'(sc[2][j]);
                    pyz_reg[i][j] <= 30'(sc[1][i]) * 30'(sc[2][j]);
                end
            sc1_reg <= sc;
        end
    end

    // Triple products in Q42; carry the pairs alongside
    logic signed [43:0] t_reg   [0:1][0:1][0:1];
    logic signed [29:0] pxy2_reg [0:1][0:1];
    logic signed [29:0] pxz2_reg [0:1][0:1];
    logic signed [29:0] pyz2_reg [0:1][0:1];
    q14_t               sc2_reg [0:2][0:1];

    always_ff @(posedge clk)
    begin
        if (adv[CL+1])
        begin
            for (int i = 0; i < 2; i++)
                for (int j = 0; j < 2; j++)
                    for (int k = 0; k < 2; k++)
                        t_reg[i][j][k] <= 44'(pxy_reg[i][j]) * 44'(sc1_reg[2][k]);
            pxy2_reg <= pxy_reg;
            pxz2_reg <= pxz_reg;
            pyz2_reg <= pyz_reg;
            sc2_reg  <= sc1_reg;
        end
    end

    // Align every term to Q42 and combine per rotation order
    logic signed [45:0] xy [0:1][0:1];
    logic signed [45:0] xz [0:1][0:1];
    logic signed [45:0] yz [0:1][0:1];
    logic signed [45:0] t  [0:1][0:1][0:1];
    logic signed [45:0] one [0:2];
    logic signed [45:0] m_next [0:8];
    logic signed [45:0] m_reg  [0:8];

    always_comb
    begin
        for (int i = 0; i < 2; i++)
            for (int j = 0; j < 2; j++)
            begin
                xy[i][j] = 46'(pxy2_reg[i][j]) <<< 14;
                xz[i][j] = 46'(pxz2_reg[i][j]) <<< 14;
                yz[i][j] = 46'(pyz2_reg[i][j]) <<< 14;
                for (int k = 0; k < 2; k++)
                    t[i][j][k] = 46'(t_reg[i][j][k]);
            end
        for (int a = 0; a < 3; a++)
            one[a] = 46'(sc2_reg[a][1]) <<< 28;

        unique case (order_reg)
            ORD_XYZ:
            begin
                m_next[0] = yz[0][0];
                m_next[1] = -yz[0][1];
                m_next[2] = one[1];
                m_next[3] = t[1][1][0] + xz[0][1];
                m_next[4] = xz[0][0] - t[1][1][1];
                m_next[5] = -xy[1][0];
                m_next[6] = xz[1][1] - t[0][1][0];
                m_next[7] = xz[1][0] + t[0][1][1];
                m_next[8] = xy[0][0];
            end
            ORD_YZX:
            begin
                m_next[0] = yz[0][0];
                m_next[1] = xy[1][1] - t[0][0][1];
                m_next[2] = xy[0][1] + t[1][0][1];
                m_next[3] = one[2];
                m_next[4] = xz[0][0];
                m_next[5] = -xz[1][0];
                m_next[6] = -yz[1][0];
                m_next[7] = xy[1][0] + t[0][1][1];
                m_next[8] = xy[0][0] - t[1][1][1];
            end
            ORD_ZXY:
            begin
                m_next[0] = yz[0][0] - t[1][1][1];
                m_next[1] = -xz[0][1];
                m_next[2] = yz[1][0] + t[1][0][1];
                m_next[3] = t[1][1][0] + yz[0][1];
                m_next[4] = xz[0][0];
                m_next[5] = yz[1][1] - t[1][0][0];
                m_next[6] = -xy[0][1];
                m_next[7] = one[0];
                m_next[8] = xy[0][0];
            end
            ORD_YXZ:
            begin
                m_next[0] = yz[0][0] + t[1][1][1];
                m_next[1] = t[1][1][0] - yz[0][1];
                m_next[2] = xy[0][1];
                m_next[3] = xz[0][1];
                m_next[4] = xz[0][0];
                m_next[5] = -one[0];
                m_next[6] = t[1][0][1] - yz[1][0];
                m_next[7] = t[1][0][0] + yz[1][1];
                m_next[8] = xy[0][0];
            end
            ORD_XZY:
            begin
                m_next[0] = yz[0][0];
                m_next[1] = -one[2];
                m_next[2] = yz[1][0];
                m_next[3] = xy[1][1] + t[0][0][1];
                m_next[4] = xz[0][0];
                m_next[5] = t[0][1][1] - xy[1][0];
                m_next[6] = t[1][0][1] - xy[0][1];
                m_next[7] = xz[1][0];
                m_next[8] = xy[0][0] + t[1][1][1];
            end
            default:
            begin
                // ZYX, also for the unused codes
                m_next[0] = yz[0][0];
                m_next[1] = t[1][1][0] - xz[0][1];
                m_next[2] = t[0][1][0] + xz[1][1];
                m_next[3] = yz[0][1];
                m_next[4] = xz[0][0] + t[1][1][1];
                m_next[5] = t[0][1][1] - xz[1][0];
                m_next[6] = -one[1];
                m_next[7] = xy[1][0];
                m_next[8] = xy[0][0];
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (adv[CL+2])
            m_reg <= m_next;
    end

    // Round to Q14 and saturate into the output register
    logic signed [45:0] r    [0:8];
    q14_t               o_next [0:8];
    q14_t               o_reg  [0:8];

    always_comb
    begin
        for (int k = 0; k < 9; k++)
        begin
            r[k] = (m_reg[k] + 46'sd134217728) >>> 28;
            if (r[k] > 46'sd16384)
                o_next[k] = 16'sd16384;
            else if (r[k] < -46'sd16384)
                o_next[k] = -16'sd16384;
            else
                o_next[k] = q14_t'(r[k]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[L-1])
            o_reg <= o_next;
    end

    assign matrix.valid = vld_reg[L-1];
    assign matrix.m00   = o_reg[0];
    assign matrix.m01   = o_reg[1];
    assign matrix.m02   = o_reg[2];
    assign matrix.m10   = o_reg[3];
    assign matrix.m11   = o_reg[4];
    assign matrix.m12   = o_reg[5];
    assign matrix.m20   = o_reg[6];
    assign matrix.m21   = o_reg[7];
    assign matrix.m22   = o_reg[8];

    // An empty output register never blocks new requests
    `E2R_ASSERT_NOW(a_ready_when_empty, !vld_reg[L-1], angles.ready)
    // A result that moves into the output register shows up as valid
    `E2R_ASSERT_NEXT(a_out_load, vld_reg[L-2] && adv[L-1], matrix.valid)
    // Diagonal element stays within plus or minus one
    `E2R_ASSERT_NOW(a_m11_range, matrix.valid,
                    (matrix.m11 <= 16'sd16384) && (matrix.m11 >= -16'sd16384))
    // An accepted request enters the first stage
    `E2R_ASSERT_NEXT(a_in_load, angles.valid && angles.ready, vld_reg[0])

endmodule

### rtl/e2r_cordic.sv
// Pipelined sine/cosine: angle fold, one CORDIC iteration per stage, rounding.
// Depends on e2r_pkg; stage enables come from the top-level valid chain.
module e2r_cordic import e2r_pkg::*;
#(
    parameter int STAGES = 16
)
(
    input  logic               clk,
    input  logic [STAGES+1:0]  en,
    input  logic signed [15:0] angle,
    output q14_t               sin_q14,
    output q14_t               cos_q14
);

    q24_t x_reg [0:STAGES];
    q24_t y_reg [0:STAGES];
    q24_t z_reg [0:STAGES];
    logic flip_reg [0:STAGES];
    q14_t sin_reg, cos_reg;

    logic signed [16:0] a_full, a_pi, a_half;
    logic               flip_next;

    // Fold into [-pi, pi], then into [-pi/2, pi/2]
    always_comb
    begin
        a_full = 17'(angle);
        if (a_full > PI_Q12)
            a_pi = a_full - TWO_PI_Q12;
        else if (a_full < -PI_Q12)
            a_pi = a_full + TWO_PI_Q12;
        else
            a_pi = a_full;
        flip_next = 1'b1;
        if (a_pi > HALF_PI_Q12)
            a_half = a_pi - PI_Q12;
        else if (a_pi < -HALF_PI_Q12)
            a_half = a_pi + PI_Q12;
        else
        begin
            a_half    = a_pi;
            flip_next = 1'b0;
        end
    end

    // Load the folded angle and the CORDIC start vector
    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            x_reg[0]    <= GAIN_Q24;
            y_reg[0]    <= '0;
            z_reg[0]    <= 28'(a_half) <<< 12;
            flip_reg[0] <= flip_next;
        end
    end

    // One rotation per stage
    for (genvar i = 0; i < STAGES; i++)
    begin : g_iter
        always_ff @(posedge clk)
        begin
            if (en[i+1])
            begin
                flip_reg[i+1] <= flip_reg[i];
                if (!z_reg[i][27])
                begin
                    x_reg[i+1] <= x_reg[i] - (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] + (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] - atan_q24(5'(i));
                end
                else
                begin
                    x_reg[i+1] <= x_reg[i] + (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] - (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] + atan_q24(5'(i));
                end
            end
        end
    end

    q24_t xf, yf, xr, yr, cos_next, sin_next;

    // Undo the fold, round to Q14 and clamp to plus or minus one
    always_comb
    begin
        xf = flip_reg[STAGES] ? -x_reg[STAGES] : x_reg[STAGES];
        yf = flip_reg[STAGES] ? -y_reg[STAGES] : y_reg[STAGES];
        xr = (xf + 28'sd512) >>> 10;
        yr = (yf + 28'sd512) >>> 10;
        if (xr > ONE_Q14)
            cos_next = ONE_Q14;
        else if (xr < -ONE_Q14)
            cos_next = -ONE_Q14;
        else
            cos_next = xr;
        if (yr > ONE_Q14)
            sin_next = ONE_Q14;
        else if (yr < -ONE_Q14)
            sin_next = -ONE_Q14;
        else
            sin_next = yr;
    end

    always_ff @(posedge clk)
    begin
        if (en[STAGES+1])
        begin
            cos_reg <= q14_t'(cos_next);
            sin_reg <= q14_t'(sin_next);
        end
    end

    assign sin_q14 = sin_reg;
    assign cos_q14 = cos_reg;

endmodule
